// File: design/iff_pkg.sv
package iff_pkg;

    localparam int unsigned DIG_W = 5;   // digit count 0..22
    localparam int unsigned NDIG  = 22;

    typedef enum logic [2:0] {
        K_DEC = 3'd0,
        K_UNS = 3'd1,
        K_OCT = 3'd2,
        K_HEX = 3'd3,
        K_HXU = 3'd4,
        K_PTR = 3'd5
    } t_kind;

    localparam logic [1:0] SZ_INT   = 2'd0;
    localparam logic [1:0] SZ_SHORT = 2'd1;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;

    // output segment selector
    typedef enum logic [2:0] {
        SEG_LPAD,
        SEG_PFX,
        SEG_ZPAD,
        SEG_ZERO,
        SEG_DIG,
        SEG_RPAD
    } t_seg;

    // controller to datapath
    typedef struct packed {
        logic load;    // capture request
        logic conv;    // one conversion step
        logic setup;   // compute lengths
        logic emit;    // drive a character this cycle
        t_seg seg;
        logic [5:0] idx;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic       conv_done;
        logic [5:0] n_lpad;
        logic [1:0] n_pfx;
        logic [5:0] n_zpad;
        logic [5:0] n_zero;
        logic [5:0] n_dig;
        logic [5:0] n_rpad;
    } t_stat;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        if (d < 4'd10) c = CH_ZERO + {4'd0, d};
        else if (upper) c = 8'h37 + {4'd0, d};
        else c = 8'h57 + {4'd0, d};
        return c;
    endfunction

endpackage

// File: design/iff_datapath.sv
module iff_datapath #(
    parameter int unsigned MAX_FIELD = 32
) (
    input  logic            i_clk,
    input  iff_pkg::t_cmd   i_cmd,
    input  logic [2:0]      i_kind,
    input  logic            i_left_align,
    input  logic            i_force_sign,
    input  logic            i_space_sign,
    input  logic            i_zero_pad,
    input  logic            i_alt_form,
    input  logic [5:0]      i_min_width,
    input  logic [6:0]      i_min_digits,
    input  logic [1:0]      i_arg_size,
    input  logic [63:0]     i_value,
    output iff_pkg::t_stat  o_stat,
    output logic [7:0]      o_char
);
    localparam logic [6:0] MAXF = 7'(MAX_FIELD);

    logic [2:0]  r_kind;
    logic        r_left, r_alt, r_zp, r_prec_none, r_neg, r_plus, r_space;
    logic [6:0]  r_width, r_prec;
    logic [63:0] r_mag;
    logic [79:0] r_bcd;      // decimal digits, built by shift-and-add-3
    logic [63:0] r_sh;       // magnitude bits still to shift in
    logic [6:0]  r_cnt;      // conversion steps left, 64 down to 0
    iff_pkg::t_stat r_stat;

    logic [63:0] n_mag;
    logic        n_neg;
    logic        n_dec;
    logic        is_sgn, is_oct, is_hex;
    logic [79:0] bcd_adj;
    logic [87:0] bcd_x, hex_x;
    logic [65:0] oct_x;
    logic [3:0]  dig [iff_pkg::NDIG];
    logic [4:0]  ndig;

    // sign and magnitude of the raw argument
    always_comb begin
        n_neg = 1'b0;
        n_mag = i_value;
        if (i_kind != 3'(iff_pkg::K_PTR)) begin
            if (i_arg_size == iff_pkg::SZ_SHORT) begin
                n_mag = {48'd0, i_value[15:0]};
                if (i_kind == 3'(iff_pkg::K_DEC) && i_value[15]) begin
                    n_neg = 1'b1;
                    n_mag = {48'd0, 16'(-i_value[15:0])};
                end
            end else if (i_arg_size == iff_pkg::SZ_INT) begin
                n_mag = {32'd0, i_value[31:0]};
                if (i_kind == 3'(iff_pkg::K_DEC) && i_value[31]) begin
                    n_neg = 1'b1;
                    n_mag = {32'd0, 32'(-i_value[31:0])};
                end
            end else if (i_kind == 3'(iff_pkg::K_DEC) && i_value[63]) begin
                n_neg = 1'b1;
                n_mag = -i_value;
            end
        end
    end

    // only decimal kinds need the converter
    assign n_dec = !(i_kind == 3'(iff_pkg::K_OCT) || i_kind == 3'(iff_pkg::K_HEX) ||
                     i_kind == 3'(iff_pkg::K_HXU) || i_kind == 3'(iff_pkg::K_PTR));
    assign is_oct = (r_kind == 3'(iff_pkg::K_OCT));
    assign is_hex = (r_kind == 3'(iff_pkg::K_HEX) || r_kind == 3'(iff_pkg::K_HXU) ||
                     r_kind == 3'(iff_pkg::K_PTR));
    assign is_sgn = (r_kind == 3'(iff_pkg::K_DEC));

    // add 3 to every BCD digit above 4 before the shift
    always_comb begin
        for (int k = 0; k < 20; k++)
            bcd_adj[4*k +: 4] = (r_bcd[4*k +: 4] > 4'd4) ? r_bcd[4*k +: 4] + 4'd3
                                                         : r_bcd[4*k +: 4];
    end

    // digits of the field, least significant first
    assign bcd_x = {8'd0, r_bcd};
    assign hex_x = {24'd0, r_mag};
    assign oct_x = {2'd0, r_mag};
    always_comb begin
        for (int k = 0; k < int'(iff_pkg::NDIG); k++) begin
            if (is_oct) dig[k] = {1'b0, oct_x[3*k +: 3]};
            else if (is_hex) dig[k] = hex_x[4*k +: 4];
            else dig[k] = bcd_x[4*k +: 4];
        end
    end

    // count significant digits, at least one
    always_comb begin
        ndig = 5'd1;
        for (int k = 1; k < int'(iff_pkg::NDIG); k++)
            if (dig[k] != 4'd0) ndig = 5'(k + 1);
    end

    // lengths of each part of the field
    logic [5:0] ndig_e, zeros, pad;
    logic [1:0] plen;
    logic       zp_mode;
    always_comb begin
        logic [6:0] z, b;
        ndig_e = (r_mag == 64'd0 && r_prec == 7'd0 && !r_prec_none) ? 6'd0 : {1'b0, ndig};
        z = (!r_prec_none && r_prec > {1'b0, ndig_e}) ? r_prec - {1'b0, ndig_e} : 7'd0;
        if (r_kind == 3'(iff_pkg::K_OCT) && r_alt &&
            ((ndig_e == 6'd0 && z == 7'd0) || (r_mag != 64'd0 && z == 7'd0)))
            z = z + 7'd1;
        zeros = 6'(z);
        if (is_sgn) plen = (r_neg || r_plus || r_space) ? 2'd1 : 2'd0;
        else if (r_kind == 3'(iff_pkg::K_PTR) ||
                 ((r_kind == 3'(iff_pkg::K_HEX) || r_kind == 3'(iff_pkg::K_HXU)) &&
                  r_alt && r_mag != 64'd0)) plen = 2'd2;
        else plen = 2'd0;
        b = {5'd0, plen} + {1'b0, zeros} + {1'b0, ndig_e};
        pad = (r_width > b) ? 6'(r_width - b) : 6'd0;
        zp_mode = !r_left && r_zp && r_prec_none;
    end

    // request capture, conversion and setup
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_left <= i_left_align;
            r_alt <= i_alt_form;
            r_zp <= i_zero_pad;
            r_plus <= i_force_sign;
            r_space <= i_space_sign;
            r_width <= ({1'b0, i_min_width} > MAXF) ? MAXF : {1'b0, i_min_width};
            r_prec_none <= i_min_digits[6];
            r_prec <= (i_min_digits > MAXF) ? MAXF : i_min_digits;
            r_neg <= n_neg;
            r_mag <= n_mag;
            r_bcd <= '0;
            r_sh <= n_mag;
            r_cnt <= n_dec ? 7'd64 : 7'd0;
        end else if (i_cmd.conv && r_cnt != 7'd0) begin
            // shift one magnitude bit into the BCD digits
            r_bcd <= {bcd_adj[78:0], r_sh[63]};
            r_sh <= {r_sh[62:0], 1'b0};
            r_cnt <= r_cnt - 7'd1;
        end
        if (i_cmd.setup) begin
            r_stat.n_lpad <= (!r_left && !zp_mode) ? pad : 6'd0;
            r_stat.n_pfx <= plen;
            r_stat.n_zpad <= zp_mode ? pad : 6'd0;
            r_stat.n_zero <= zeros;
            r_stat.n_dig <= ndig_e;
            r_stat.n_rpad <= r_left ? pad : 6'd0;
        end
    end

    always_comb begin
        o_stat.conv_done = (r_cnt == 7'd0);
        o_stat.n_lpad = r_stat.n_lpad;
        o_stat.n_pfx = r_stat.n_pfx;
        o_stat.n_zpad = r_stat.n_zpad;
        o_stat.n_zero = r_stat.n_zero;
        o_stat.n_dig = r_stat.n_dig;
        o_stat.n_rpad = r_stat.n_rpad;
    end

    // character for the current segment position
    always_comb begin
        o_char = iff_pkg::CH_SPACE;
        unique case (i_cmd.seg)
            iff_pkg::SEG_LPAD, iff_pkg::SEG_RPAD: o_char = iff_pkg::CH_SPACE;
            iff_pkg::SEG_PFX: begin
                if (is_sgn)
                    o_char = r_neg ? iff_pkg::CH_MINUS :
                             r_plus ? iff_pkg::CH_PLUS : iff_pkg::CH_SPACE;
                else if (i_cmd.idx == 6'd0) o_char = iff_pkg::CH_ZERO;
                else o_char = (r_kind == 3'(iff_pkg::K_HXU)) ? iff_pkg::CH_UX : iff_pkg::CH_LX;
            end
            iff_pkg::SEG_ZPAD, iff_pkg::SEG_ZERO: o_char = iff_pkg::CH_ZERO;
            iff_pkg::SEG_DIG: o_char = iff_pkg::digit_char(
                dig[5'(r_stat.n_dig - 6'd1 - i_cmd.idx)],
                r_kind == 3'(iff_pkg::K_HXU));
            default: o_char = iff_pkg::CH_SPACE;
        endcase
    end
endmodule

// File: design/iff_ctrl.sv
module iff_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic            o_out_last,
    input  iff_pkg::t_stat  i_stat,
    output iff_pkg::t_cmd   o_cmd
);
    typedef enum logic [2:0] {S_IDLE, S_CONV, S_SETUP, S_EMIT} t_state;

    t_state        r_state, n_state;
    iff_pkg::t_seg r_seg, n_seg;
    logic [5:0]    r_idx, n_idx;

    function automatic logic [5:0] seg_len(input iff_pkg::t_seg s, input iff_pkg::t_stat st);
        logic [5:0] l;
        unique case (s)
            iff_pkg::SEG_LPAD: l = st.n_lpad;
            iff_pkg::SEG_PFX:  l = {4'd0, st.n_pfx};
            iff_pkg::SEG_ZPAD: l = st.n_zpad;
            iff_pkg::SEG_ZERO: l = st.n_zero;
            iff_pkg::SEG_DIG:  l = st.n_dig;
            iff_pkg::SEG_RPAD: l = st.n_rpad;
            default:           l = 6'd0;
        endcase
        return l;
    endfunction

    // find first nonempty segment at or after s
    function automatic logic [3:0] next_seg(input logic [3:0] s, input iff_pkg::t_stat st);
        logic [3:0] r;
        r = 4'd6;
        for (int k = 5; k >= 0; k--)
            if (4'(k) >= s && seg_len(iff_pkg::t_seg'(3'(k)), st) != 6'd0) r = 4'(k);
        return r;
    endfunction

    logic [3:0] first, after;
    logic       at_end;
    assign first = next_seg(4'd0, i_stat);
    assign at_end = (r_idx == seg_len(r_seg, i_stat) - 6'd1);
    assign after = next_seg({1'b0, r_seg} + 4'd1, i_stat);

    always_comb begin
        n_state = r_state;
        n_seg = r_seg;
        n_idx = r_idx;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_CONV;
            S_CONV:  if (i_stat.conv_done) n_state = S_SETUP;
            S_SETUP: begin
                n_idx = '0;
                if (first == 4'd6) n_state = S_IDLE;
                else begin
                    n_seg = iff_pkg::t_seg'(first[2:0]);
                    n_state = S_EMIT;
                end
            end
            S_EMIT: if (i_out_ready) begin
                if (!at_end) n_idx = r_idx + 6'd1;
                else if (after == 4'd6) n_state = S_IDLE;
                else begin
                    n_idx = '0;
                    n_seg = iff_pkg::t_seg'(after[2:0]);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // hold state and segment position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_seg <= iff_pkg::SEG_LPAD;
            r_idx <= '0;
        end else begin
            r_state <= n_state;
            r_seg <= n_seg;
            r_idx <= n_idx;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);
    assign o_out_last = at_end && (after == 4'd6);
    assign o_cmd.load = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.conv = (r_state == S_CONV);
    assign o_cmd.setup = (r_state == S_CONV) && i_stat.conv_done;
    assign o_cmd.emit = o_out_valid;
    assign o_cmd.seg = r_seg;
    assign o_cmd.idx = r_idx;
endmodule

// File: design/integer_field_formatter.sv
// Integer field formatter: printf-style d/i/u/o/x/X/p text, one char per word.
// Slave channel takes one request word; master channel emits the field's
// ASCII characters in order, tlast on the final one. A field that yields no
// characters produces no output words.
// Decimal magnitudes go through a shift-and-add-3 converter, one bit per
// cycle; octal, hex and pointer digits come straight from the magnitude.
// A setup state follows, then one character per cycle while the receiver
// accepts. The next request is taken only once the current field is
// finished.
// One request is in flight at a time; s_axis_tready is high only when idle.
// When the receiver stalls, the current character and tlast hold steady.
// Reset (i_rst_n low, synchronous) returns to idle with no output pending.
module integer_field_formatter #(
    parameter int unsigned MAX_FIELD = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // kind[2:0], left_align, force_sign, space_sign, zero_pad, alt_form,
    // min_width[13:8], min_digits[20:14], arg_size[22:21], value[86:23], pad
    input  logic [87:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_char[7:0]
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast
);
    iff_pkg::t_cmd  cmd;
    iff_pkg::t_stat stat;

    iff_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_out_last(m_axis_tlast), .i_stat(stat), .o_cmd(cmd)
    );

    iff_datapath #(.MAX_FIELD(MAX_FIELD)) u_dp (
        .i_clk(i_clk), .i_cmd(cmd),
        .i_kind(s_axis_tdata[2:0]), .i_left_align(s_axis_tdata[3]),
        .i_force_sign(s_axis_tdata[4]), .i_space_sign(s_axis_tdata[5]),
        .i_zero_pad(s_axis_tdata[6]), .i_alt_form(s_axis_tdata[7]),
        .i_min_width(s_axis_tdata[13:8]), .i_min_digits(s_axis_tdata[20:14]),
        .i_arg_size(s_axis_tdata[22:21]), .i_value(s_axis_tdata[86:23]),
        .o_stat(stat), .o_char(m_axis_tdata)
    );

    logic unused_pad;
    assign unused_pad = s_axis_tdata[87];

`ifndef SYNTHESIS
    // no new request accepted while characters are pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("accept during emit");
    // a field always ends with tlast before returning idle
    a_last_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
        else $error("field ended without tlast");
    // setup comes only after conversion finished
    a_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.setup |-> stat.conv_done) else $error("setup before done");
`endif
endmodule
